@@ hw/rtl/mec_pkg.sv @@
// ----------------------------------------------------------------------------
// mec_pkg: shared constants of the Mandelbrot escape counter
// Fixed field widths and default values for the parameters.
// ----------------------------------------------------------------------------
package mec_pkg;

    localparam int Z_W           = 32;
    localparam int TALLY_W       = 32;
    localparam int ITER_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF = 28;
    localparam int MAX_ITER_RST  = 2000;

endpackage

@@ hw/rtl/mandelbrot_escape_counter.sv @@
// ----------------------------------------------------------------------------
// mandelbrot_escape_counter: escape-time iteration for one point per item
// Iterates z = z*z + c in signed fixed point and reports escape, count and
// a saturating per-batch tally of escaped points.
// ----------------------------------------------------------------------------
// A point passes ST_RR, ST_II and ST_CHK, then per iteration done (at most
// max_iter) ST_RI, ST_UPD (update), ST_RR, ST_II and ST_CHK (escape check),
// then ST_FIN. One signed 32x32 multiplier is shared by zr*zr, zi*zi and
// zr*zi. The input side is ready only while no point is at work; a finished
// result waits in the output register and the next point may be accepted
// meanwhile. The user must write max_iter through cfg_we / cfg_wdata only
// while the block is idle; the block does not enforce it.
module mandelbrot_escape_counter #(
    parameter int ITER_BITS = mec_pkg::ITER_BITS_DEF,
    parameter int FRAC_BITS = mec_pkg::FRAC_BITS_DEF
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         cfg_we,
    input  logic [ITER_BITS-1:0]                         cfg_wdata,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // c_real, c_imag
    input  logic [2*mec_pkg::Z_W-1:0]                    s_tdata,
    input  logic                                         s_tlast,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // escaped, iterations, outside_total, zero fill
    output logic [((ITER_BITS+mec_pkg::TALLY_W+8)/8)*8-1:0] m_tdata,
    output logic                                         m_tlast
);
    import mec_pkg::*;

    localparam int OUT_W = ((ITER_BITS + TALLY_W + 8) / 8) * 8;
    localparam int P_W   = 2 * Z_W;
    localparam logic [P_W:0] LIMIT = (2 * FRAC_BITS + 2 < P_W) ?
        ((P_W+1)'(4) << (2 * FRAC_BITS)) : {(P_W+1){1'b1}};
    localparam logic signed [P_W-1:0] Z_MAX = P_W'(signed'({1'b0, {(Z_W-1){1'b1}}}));
    localparam logic signed [P_W-1:0] Z_MIN = -Z_MAX - P_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_RR, ST_II, ST_CHK, ST_RI, ST_UPD, ST_FIN
    } state_t;

    state_t                   state_reg;
    logic [ITER_BITS-1:0]     max_iter_reg;
    logic [ITER_BITS-1:0]     k_reg;
    logic signed [Z_W-1:0]    cr_reg, ci_reg, zr_reg, zi_reg;
    logic signed [P_W-1:0]    rr_reg, ii_reg, ri_reg;
    logic                     esc_reg, last_reg;
    logic [TALLY_W-1:0]       tally_reg;
    logic                     m_tvalid_reg, m_tlast_reg;
    logic [OUT_W-1:0]         m_tdata_reg;

    logic signed [Z_W-1:0]    mul_a, mul_b;
    logic signed [P_W-1:0]    mul_p;
    logic [P_W:0]             mag_sum;
    logic signed [P_W-1:0]    diff, nr_full, ni_full;
    logic signed [Z_W-1:0]    zr_next, zi_next;
    logic [TALLY_W-1:0]       tally_next;
    logic                     out_free;

    function automatic logic signed [Z_W-1:0] sat_z(input logic signed [P_W-1:0] v);
        logic signed [Z_W-1:0] r;
        if (v > Z_MAX) begin
            r = Z_MAX[Z_W-1:0];
        end else if (v < Z_MIN) begin
            r = Z_MIN[Z_W-1:0];
        end else begin
            r = v[Z_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        case (state_reg)
            ST_RR: begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            ST_II: begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            default: begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
        endcase
    end

    assign mul_p   = P_W'(mul_a) * P_W'(mul_b);
    assign mag_sum = {1'b0, rr_reg} + {1'b0, ii_reg};
    assign diff    = rr_reg - ii_reg;
    assign nr_full = (diff >>> FRAC_BITS) + P_W'(cr_reg);
    assign ni_full = (ri_reg >>> (FRAC_BITS - 1)) + P_W'(ci_reg);
    assign zr_next = sat_z(nr_full);
    assign zi_next = sat_z(ni_full);
    assign tally_next = (esc_reg && (tally_reg != {TALLY_W{1'b1}})) ?
                        tally_reg + TALLY_W'(1) : tally_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            max_iter_reg <= ITER_BITS'(MAX_ITER_RST);
            tally_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            k_reg        <= '0;
            esc_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                max_iter_reg <= cfg_wdata;
            end
            if (m_tvalid_reg && m_tready && (state_reg != ST_FIN)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cr_reg    <= s_tdata[Z_W-1:0];
                        ci_reg    <= s_tdata[P_W-1:Z_W];
                        zr_reg    <= s_tdata[Z_W-1:0];
                        zi_reg    <= s_tdata[P_W-1:Z_W];
                        last_reg  <= s_tlast;
                        k_reg     <= '0;
                        esc_reg   <= 1'b0;
                        state_reg <= ST_RR;
                    end
                end
                ST_RR: begin
                    rr_reg    <= mul_p;
                    state_reg <= ST_II;
                end
                ST_II: begin
                    ii_reg    <= mul_p;
                    state_reg <= ST_CHK;
                end
                ST_CHK: begin
                    if ((k_reg != '0) && (mag_sum > LIMIT)) begin
                        esc_reg   <= 1'b1;
                        state_reg <= ST_FIN;
                    end else if (k_reg == max_iter_reg) begin
                        state_reg <= ST_FIN;
                    end else begin
                        state_reg <= ST_RI;
                    end
                end
                ST_RI: begin
                    ri_reg    <= mul_p;
                    state_reg <= ST_UPD;
                end
                ST_UPD: begin
                    zr_reg    <= zr_next;
                    zi_reg    <= zi_next;
                    k_reg     <= k_reg + ITER_BITS'(1);
                    state_reg <= ST_RR;
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tlast_reg  <= last_reg;
                        m_tdata_reg  <= OUT_W'({tally_next, k_reg, esc_reg});
                        tally_reg    <= last_reg ? '0 : tally_next;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_iter_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (k_reg <= max_iter_reg))
        else $error("iteration count beyond max_iter");

    a_esc_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[ITER_BITS:1] != '0))
        else $error("escaped result with zero iterations");

    a_esc_tally: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[ITER_BITS+TALLY_W:ITER_BITS+1] != '0))
        else $error("escaped result with zero tally");

    a_tally_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_FIN) |=> $stable(tally_reg))
        else $error("tally moved outside result step");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for mandelbrot_escape_counter
// Streams complex points into the block under bursty input traffic and a
// stalling result side. Each accepted point is run through an in-bench
// escape-time calculation, and every result is compared field by field.
// Covers the default limit, zero and full-scale iteration limits,
// saturating points, a long output hold-off, and random batches of points.
// ----------------------------------------------------------------------------
module testbench;

    import mec_pkg::*;

    localparam int ITER_W = ITER_BITS_DEF;
    localparam int FRAC   = FRAC_BITS_DEF;
    localparam int RES_W  = ((ITER_W + TALLY_W + 8) / 8) * 8;
    localparam logic [63:0] ESCAPE_LIMIT = 64'd4 << (2 * FRAC);

    typedef struct packed {
        logic              esc;
        logic [ITER_W-1:0] iters;
        logic [TALLY_W-1:0] total;
        logic              batch_end;
    } escape_result_t;

    typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_mode_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [ITER_W-1:0]    cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [2*Z_W-1:0]     s_tdata;    // c_real, c_imag
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [RES_W-1:0]     m_tdata;    // escaped, iterations, outside_total, zero fill
    logic                 m_tlast;

    escape_result_t pending_escapes[$];
    int unsigned    iter_limit;
    logic [TALLY_W-1:0] batch_tally;

    int          mismatches;
    int          points_sent;
    int          results_checked;
    int          escapes_seen;
    int          batches_closed;
    int          gap_max;
    int          burst_left;
    int          hold_left;
    ready_mode_t ready_mode;

    mandelbrot_escape_counter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #(200_000_000);
        $display("Verification failed");
        $finish;
    end

    function automatic longint clamp32(input longint v);
        if (v > longint'(32'sh7FFF_FFFF)) begin
            return longint'(32'sh7FFF_FFFF);
        end
        if (v < -longint'(64'sh8000_0000)) begin
            return -longint'(64'sh8000_0000);
        end
        return v;
    endfunction

    function automatic escape_result_t compute_escape(input logic [31:0] re,
                                                      input logic [31:0] im,
                                                      input logic last);
        escape_result_t r;
        longint cr, ci, zr, zi, rr, ii, ri;
        logic [63:0] sq_r, sq_i;
        int unsigned k;
        logic esc;
        cr  = longint'($signed(re));
        ci  = longint'($signed(im));
        zr  = cr;
        zi  = ci;
        k   = 0;
        esc = 1'b0;
        while (k < iter_limit && !esc) begin
            rr   = zr * zr;
            ii   = zi * zi;
            ri   = zr * zi;
            zr   = clamp32(((rr - ii) >>> FRAC) + cr);
            zi   = clamp32((ri >>> (FRAC - 1)) + ci);
            k++;
            sq_r = zr * zr;
            sq_i = zi * zi;
            if (sq_r + sq_i > ESCAPE_LIMIT) begin
                esc = 1'b1;
            end
        end
        if (esc && batch_tally != '1) begin
            batch_tally++;
        end
        r.esc       = esc;
        r.iters     = k[ITER_W-1:0];
        r.total     = batch_tally;
        r.batch_end = last;
        if (last) begin
            batch_tally = '0;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom();
            8, 9:    return ($urandom_range(0, 1) ? 32'h2000_0000 : 32'hE000_0000)
                            + 32'($signed($urandom_range(0, 2048)) - 1024);
            default: return 32'($signed($urandom_range(0, 32'd1342177280)) - 671088640);
        endcase
    endfunction

    // result side: stall by mode, or hold off entirely while hold_left runs down
    initial begin
        int stall_phase;
        stall_phase = 0;
        m_tready <= 1'b0;
        forever begin
            @(negedge aclk);
            stall_phase++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (ready_mode)
                    READY_ALWAYS:  m_tready <= 1'b1;
                    READY_RANDOM:  m_tready <= ($urandom_range(0, 2) != 0);
                    READY_PATTERN: m_tready <= ((stall_phase % 7) >= 2);
                    default:       m_tready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge aclk) begin : check_result
        escape_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (m_tdata[0]) begin
                escapes_seen++;
            end
            if (pending_escapes.size() == 0) begin
                $error("result item with no point pending");
                mismatches++;
            end else begin
                want = pending_escapes.pop_front();
                check_field("escaped", want.esc, m_tdata[0]);
                check_field("iterations", want.iters, m_tdata[ITER_W:1]);
                check_field("outside_total", want.total, m_tdata[ITER_W+TALLY_W:ITER_W+1]);
                check_field("batch_end", want.batch_end, m_tlast);
            end
        end
    end

    task automatic send_point(input logic [31:0] re, input logic [31:0] im,
                              input logic last);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        end
        burst_left--;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {im, re};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        pending_escapes.push_back(compute_escape(re, im, last));
        points_sent++;
        if (last) begin
            batches_closed++;
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_escapes.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_iter_limit(input int unsigned value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value[ITER_W-1:0];
        @(negedge aclk);
        cfg_we    <= 1'b0;
        iter_limit = value;
    endtask

    task automatic test_default_limit();
        gap_max    = 3;
        ready_mode = READY_RANDOM;
        send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_point(32'hE000_0000, 32'h0000_0000, 1'b0);
        send_point(32'h0400_0000, 32'h0000_0000, 1'b0);
        send_point(32'h0000_0000, 32'h1000_0000, 1'b0);
        send_point(32'h0800_0000, 32'h0000_0000, 1'b0);
        send_point(32'hF400_0000, 32'h0199_999A, 1'b1);
        drain();
    endtask

    task automatic test_saturating_points();
        set_iter_limit(65535);
        ready_mode = READY_PATTERN;
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_point(32'h8000_0000, 32'h0000_0000, 1'b0);
        send_point(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_point(32'h0000_0000, 32'h0000_0000, 1'b1);
        drain();
    endtask

    task automatic test_zero_limit();
        set_iter_limit(0);
        ready_mode = READY_ALWAYS;
        gap_max    = 0;
        send_point(32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
        send_point(32'h1000_0000, 32'h1000_0000, 1'b0);
        send_point(32'h0000_0000, 32'h0000_0000, 1'b1);
        drain();
    endtask

    task automatic test_single_iteration();
        set_iter_limit(1);
        ready_mode = READY_RANDOM;
        gap_max    = 2;
        send_point(32'h2000_0000, 32'h0000_0000, 1'b0);
        send_point(32'h1000_0000, 32'h1000_0000, 1'b0);
        send_point(32'hE000_0000, 32'h0000_0000, 1'b1);
        drain();
    endtask

    task automatic test_output_backpressure();
        set_iter_limit(8);
        ready_mode = READY_ALWAYS;
        gap_max    = 0;
        hold_left  = 400;
        repeat (20) begin
            send_point(rand_coord(), rand_coord(), ($urandom_range(0, 7) == 0));
        end
        drain();
    endtask

    task automatic test_random_points();
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       set_iter_limit(16);
                1:       set_iter_limit($urandom_range(1, 64));
                2:       set_iter_limit(2);
                3:       set_iter_limit(64);
                default: set_iter_limit($urandom_range(1, 32));
            endcase
            ready_mode = ready_mode_t'(phase % 3);
            gap_max    = (phase == 3) ? 0 : $urandom_range(1, 6);
            repeat (56) begin
                send_point(rand_coord(), rand_coord(), ($urandom_range(0, 7) == 0));
            end
            drain();
        end
    endtask

    initial begin
        mismatches      = 0;
        points_sent     = 0;
        results_checked = 0;
        escapes_seen    = 0;
        batches_closed  = 0;
        gap_max         = 0;
        burst_left      = 0;
        hold_left       = 0;
        ready_mode      = READY_ALWAYS;
        iter_limit      = MAX_ITER_RST;
        batch_tally     = '0;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_default_limit();
        test_saturating_points();
        test_zero_limit();
        test_single_iteration();
        test_output_backpressure();
        test_random_points();

        repeat (20) @(posedge aclk);
        $display("Sent %0d points in %0d closed batches; checked %0d results, %0d escaped.",
                 points_sent, batches_closed, results_checked, escapes_seen);
        $display("Limits 0, 1, 2000, 65535 and random; saturating, boundary, output hold-off.");
        if (mismatches == 0 && pending_escapes.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ mandelbrot_escape_counter.f @@
hw/rtl/mec_pkg.sv
hw/rtl/mandelbrot_escape_counter.sv
bench/testbench.sv
